FILE: rtl/core/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse block.
package m3i_pkg;

   localparam int ELEM_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int LANES      = 9;
   localparam int THR_W      = 31;

   // signed cofactor and determinant widths; numerator, remainder and compare widths
   localparam int COF_W = 2 * ELEM_WIDTH + 1;
   localparam int DET_W = 3 * ELEM_WIDTH + 3;
   localparam int NUM_W = COF_W + 2 * FRAC_BITS;
   localparam int REM_W = (NUM_W > DET_W + ELEM_WIDTH) ? NUM_W : DET_W + ELEM_WIDTH;
   localparam int CMP_W = (DET_W > THR_W + 2 * FRAC_BITS) ? DET_W : THR_W + 2 * FRAC_BITS;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;

   typedef struct packed {
      elem_type m_0;
      elem_type m_1;
      elem_type m_2;
      elem_type m_3;
      elem_type m_4;
      elem_type m_5;
      elem_type m_6;
      elem_type m_7;
      elem_type m_8;
   } req_type;

   typedef struct packed {
      elem_type inv_0;
      elem_type inv_1;
      elem_type inv_2;
      elem_type inv_3;
      elem_type inv_4;
      elem_type inv_5;
      elem_type inv_6;
      elem_type inv_7;
      elem_type inv_8;
      logic     singular;
   } rsp_type;

   // classified request handed from the front to the divider
   typedef struct packed {
      logic                         singular;
      logic [DET_W-1:0]             absdet;
      logic [LANES-1:0]             neg;
      logic [LANES-1:0]             ovf;
      logic [LANES-1:0][COF_W-1:0]  mag;
   } task_type;

endpackage

FILE: rtl/core/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse: front, task queue, divider and result queue.
//
// Usage: push one request per cycle on req_ (nine column-major Q16.16
// elements); a request is taken when req_push is high and req_full is low.
// Results leave in request order on rsp_: while rsp_empty is low the oldest
// result sits on rsp_data and is taken when rsp_pop is high.
// csr_we writes csr_wdata into the singular threshold (Q16.16 magnitude);
// write it only while no request is in flight. Reset value is 1.
// Throughput: one request per cycle while the receiver keeps up, set by the
// 7-stage front pipeline and the one-bit-per-stage divider (ELEM_WIDTH
// stages, nine lanes each). A queue of QUEUE_DEPTH entries separates front
// and divider; a two-entry queue holds finished results. When the receiver
// stalls the divider holds, then the task queue fills, then the front holds
// and req_full rises.
// Reset (synchronous, active high) empties all queues and pipelines.
module matrix3x3_inverse #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  m3i_pkg::req_type          req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output m3i_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [m3i_pkg::THR_W-1:0] csr_wdata
);
   import m3i_pkg::*;

   localparam int OUT_DEPTH = 2;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic             task_push, task_full, task_empty, task_pop;
   task_type         task_wr, task_rd;
   logic             out_push, out_full;
   rsp_type          out_data;

   // threshold register: load on every write strobe
   assign thr_in = csr_we ? csr_wdata : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else begin
         thr_ff <= thr_in;
      end
   end

   // classify: cofactors, determinant, singular and overflow flags
   m3i_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .thr       (thr_ff),
      .task_push (task_push),
      .task_full (task_full),
      .task_data (task_wr)
   );

   // decouple front and divider so each stalls on its own
   m3i_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .data_type (task_type)
   ) u_task_q (
      .clock     (clock),
      .reset     (reset),
      .push      (task_push),
      .full      (task_full),
      .push_data (task_wr),
      .pop       (task_pop),
      .empty     (task_empty),
      .pop_data  (task_rd)
   );

   // divide nine cofactors by the determinant, saturate
   m3i_back u_back (
      .clock      (clock),
      .reset      (reset),
      .task_empty (task_empty),
      .task_pop   (task_pop),
      .task_data  (task_rd),
      .out_push   (out_push),
      .out_full   (out_full),
      .out_data   (out_data)
   );

   // hold finished results for the receiver
   m3i_fifo #(
      .DEPTH     (OUT_DEPTH),
      .data_type (rsp_type)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .full      (out_full),
      .push_data (out_data),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_data)
   );

endmodule

FILE: rtl/core/m3i_fifo.sv
// Small register queue with push/full and pop/empty handshakes.
module m3i_fifo #(
   parameter int  DEPTH     = 4,
   parameter type data_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  data_type push_data,
   input  logic     pop,
   output logic     empty,
   output data_type pop_data
);
   localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   data_type           store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/m3i_front.sv
// Front pipeline: cofactors, determinant and singular/overflow classification.
module m3i_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  m3i_pkg::req_type         req_data,
   input  logic [m3i_pkg::THR_W-1:0] thr,
   output logic                     task_push,
   input  logic                     task_full,
   output m3i_pkg::task_type        task_data
);
   import m3i_pkg::*;

   localparam int E   = ELEM_WIDTH;
   localparam int P_W = 2 * ELEM_WIDTH;
   localparam int NST = 7;

   // cofactor k = m[a]*m[b] - m[c]*m[d]
   localparam int COF_IDX [LANES][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   typedef struct packed {
      logic [LANES-1:0][P_W-1:0] pa;
      logic [LANES-1:0][P_W-1:0] pb;
      logic [2:0][E-1:0]         mr;
   } s1_type;

   typedef struct packed {
      logic [LANES-1:0][COF_W-1:0] cof;
      logic [2:0][E-1:0]           mr;
   } s2_type;

   typedef struct packed {
      logic [LANES-1:0][COF_W-1:0] cof;
      logic [2:0][COF_W-1:0]       lo;
      logic [2:0][COF_W-1:0]       hi;
   } s3_type;

   typedef struct packed {
      logic [LANES-1:0][COF_W-1:0] cof;
      logic [2:0][DET_W-1:0]       term;
   } s4_type;

   typedef struct packed {
      logic [LANES-1:0][COF_W-1:0] cof;
      logic [DET_W-1:0]            det;
   } s5_type;

   typedef struct packed {
      logic [LANES-1:0][COF_W-1:0] mag;
      logic [LANES-1:0]            cneg;
      logic [DET_W-1:0]            absdet;
      logic                        dneg;
   } s6_type;

   elem_type         m [LANES];
   logic             adv;
   logic [NST-1:0]   valid_ff, valid_in;
   s1_type           s1_ff, s1_in;
   s2_type           s2_ff, s2_in;
   s3_type           s3_ff, s3_in;
   s4_type           s4_ff, s4_in;
   s5_type           s5_ff, s5_in;
   s6_type           s6_ff, s6_in;
   task_type         s7_ff, s7_in;

   assign m[0] = req_data.m_0;
   assign m[1] = req_data.m_1;
   assign m[2] = req_data.m_2;
   assign m[3] = req_data.m_3;
   assign m[4] = req_data.m_4;
   assign m[5] = req_data.m_5;
   assign m[6] = req_data.m_6;
   assign m[7] = req_data.m_7;
   assign m[8] = req_data.m_8;

   // hold the whole pipe while the queue cannot take the last stage
   assign adv       = !valid_ff[NST-1] || !task_full;
   assign req_full  = !adv;
   assign task_push = valid_ff[NST-1] && !task_full;
   assign task_data = s7_ff;
   assign valid_in  = {valid_ff[NST-2:0], req_push};

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         s1_in.pa[k] = P_W'(m[COF_IDX[k][0]] * m[COF_IDX[k][1]]);
         s1_in.pb[k] = P_W'(m[COF_IDX[k][2]] * m[COF_IDX[k][3]]);
      end
      s1_in.mr[0] = m[0];
      s1_in.mr[1] = m[3];
      s1_in.mr[2] = m[6];
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         s2_in.cof[k] = {s1_ff.pa[k][P_W-1], s1_ff.pa[k]} - {s1_ff.pb[k][P_W-1], s1_ff.pb[k]};
      end
      s2_in.mr = s1_ff.mr;
   end

   // split each row-0 cofactor product into two narrow partial products
   always_comb begin
      s3_in.cof = s2_ff.cof;
      for (int j = 0; j < 3; j++) begin
         s3_in.lo[j] = COF_W'($signed(s2_ff.mr[j]) * $signed({1'b0, s2_ff.cof[j][E-1:0]}));
         s3_in.hi[j] = COF_W'($signed(s2_ff.mr[j]) * $signed(s2_ff.cof[j][COF_W-1:E]));
      end
   end

   always_comb begin
      s4_in.cof = s3_ff.cof;
      for (int j = 0; j < 3; j++) begin
         s4_in.term[j] = ({{(DET_W-COF_W){s3_ff.hi[j][COF_W-1]}}, s3_ff.hi[j]} << E)
                       + {{(DET_W-COF_W){s3_ff.lo[j][COF_W-1]}}, s3_ff.lo[j]};
      end
   end

   always_comb begin
      s5_in.cof = s4_ff.cof;
      s5_in.det = s4_ff.term[0] + s4_ff.term[1] + s4_ff.term[2];
   end

   always_comb begin
      s6_in.dneg   = s5_ff.det[DET_W-1];
      s6_in.absdet = s5_ff.det[DET_W-1] ? -s5_ff.det : s5_ff.det;
      for (int k = 0; k < LANES; k++) begin
         s6_in.cneg[k] = s5_ff.cof[k][COF_W-1];
         s6_in.mag[k]  = s5_ff.cof[k][COF_W-1] ? -s5_ff.cof[k] : s5_ff.cof[k];
      end
   end

   // singular below the scaled threshold; overflow when quotient reaches 2^E
   always_comb begin
      s7_in.absdet   = s6_ff.absdet;
      s7_in.mag      = s6_ff.mag;
      s7_in.singular = (s6_ff.absdet == '0)
                    || (CMP_W'(s6_ff.absdet) < (CMP_W'(thr) << (2 * FRAC_BITS)));
      for (int k = 0; k < LANES; k++) begin
         s7_in.neg[k] = s6_ff.cneg[k] ^ s6_ff.dneg;
         s7_in.ovf[k] = (REM_W'(s6_ff.mag[k]) << (2 * FRAC_BITS))
                     >= (REM_W'(s6_ff.absdet) << E);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

endmodule

FILE: rtl/core/m3i_back.sv
// Back pipeline: one quotient bit per stage for all nine lanes, then saturation.
module m3i_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 task_empty,
   output logic                 task_pop,
   input  m3i_pkg::task_type    task_data,
   output logic                 out_push,
   input  logic                 out_full,
   output m3i_pkg::rsp_type     out_data
);
   import m3i_pkg::*;

   localparam int E = ELEM_WIDTH;

   typedef struct packed {
      logic                        singular;
      logic [DET_W-1:0]            absdet;
      logic [LANES-1:0]            neg;
      logic [LANES-1:0]            ovf;
      logic [LANES-1:0][REM_W-1:0] rem;
      logic [LANES-1:0][E-1:0]     quo;
   } div_type;

   localparam logic [E-1:0] POS_MAX = {1'b0, {(E-1){1'b1}}};
   localparam logic [E-1:0] NEG_MIN = {1'b1, {(E-1){1'b0}}};

   logic         adv;
   logic [E:0]   valid_ff, valid_in;
   div_type      div_ff [E+1];
   div_type      div_in [E+1];
   elem_type     inv [LANES];
   div_type      last;

   assign adv      = !valid_ff[E] || !out_full;
   assign task_pop = !task_empty && adv;
   assign out_push = valid_ff[E] && !out_full;
   assign valid_in = {valid_ff[E-1:0], task_pop};

   always_comb begin
      div_in[0].singular = task_data.singular;
      div_in[0].absdet   = task_data.absdet;
      div_in[0].neg      = task_data.neg;
      div_in[0].ovf      = task_data.ovf;
      for (int k = 0; k < LANES; k++) begin
         div_in[0].rem[k] = REM_W'(task_data.mag[k]) << (2 * FRAC_BITS);
         div_in[0].quo[k] = '0;
      end
   end

   // restoring step: subtract the shifted divisor where it fits
   for (genvar i = 1; i <= E; i++) begin : g_stage
      localparam int B = E - i;
      always_comb begin : p_step
         logic [REM_W:0] diff;
         div_in[i] = div_ff[i-1];
         for (int k = 0; k < LANES; k++) begin
            diff = {1'b0, div_ff[i-1].rem[k]} - ((REM_W + 1)'(div_ff[i-1].absdet) << B);
            if (!diff[REM_W]) begin
               div_in[i].rem[k]    = diff[REM_W-1:0];
               div_in[i].quo[k][B] = 1'b1;
            end
         end
      end
   end

   assign last = div_ff[E];

   // saturate to the signed element range and apply the sign
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if (last.singular) begin
            inv[k] = '0;
         end else if (last.ovf[k]) begin
            inv[k] = last.neg[k] ? NEG_MIN : POS_MAX;
         end else if (last.neg[k]) begin
            inv[k] = (last.quo[k] > NEG_MIN) ? NEG_MIN : -last.quo[k];
         end else begin
            inv[k] = last.quo[k][E-1] ? POS_MAX : last.quo[k];
         end
      end
      out_data.inv_0    = inv[0];
      out_data.inv_1    = inv[1];
      out_data.inv_2    = inv[2];
      out_data.inv_3    = inv[3];
      out_data.inv_4    = inv[4];
      out_data.inv_5    = inv[5];
      out_data.inv_6    = inv[6];
      out_data.inv_7    = inv[7];
      out_data.inv_8    = inv[8];
      out_data.singular = last.singular;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= E; i++) begin
            div_ff[i] <= div_in[i];
         end
      end
   end

endmodule

FILE: sim/tb_matrix3x3_inverse.sv
// Testbench for matrix3x3_inverse: directed and random matrices checked against a fixed-point predictor.
`timescale 1ns / 1ps

module tb_matrix3x3_inverse;
   import m3i_pkg::*;

   localparam int LATENCY_WAIT = ELEM_WIDTH + 30;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   req_type              req_data = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [THR_W-1:0]     csr_wdata = '0;

   // threshold as the block currently holds it
   logic [THR_W-1:0]     threshold = THR_W'(1);
   rsp_type              inverse_q[$];
   int                   fail_count = 0;
   int                   request_count = 0;
   int                   result_count = 0;
   int                   singular_count = 0;
   int                   saturate_count = 0;
   // when set, neither side idles
   bit                   steady = 1'b0;

   matrix3x3_inverse u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact inverse: cofactors and determinant at full width, quotient
   // truncated toward zero, then clamped to the element range.
   function automatic rsp_type invert_matrix(req_type r, logic [THR_W-1:0] thr);
      logic [9*ELEM_WIDTH-1:0] flat_in;
      logic [9*ELEM_WIDTH-1:0] flat_out;
      logic signed [127:0]     m[9];
      logic signed [127:0]     cof[9];
      logic signed [127:0]     det;
      logic [127:0]            absdet;
      logic [127:0]            num;
      logic [127:0]            quo;
      logic [127:0]            lim;
      logic [127:0]            limit_thr;
      logic [127:0]            v;
      logic                    neg;
      rsp_type                 res;
      flat_in = r;
      for (int k = 0; k < 9; k++) begin
         m[k] = 128'($signed(flat_in[(8-k)*ELEM_WIDTH +: ELEM_WIDTH]));
      end
      cof[0] = m[4]*m[8] - m[5]*m[7];
      cof[1] = m[2]*m[7] - m[1]*m[8];
      cof[2] = m[1]*m[5] - m[2]*m[4];
      cof[3] = m[5]*m[6] - m[3]*m[8];
      cof[4] = m[0]*m[8] - m[2]*m[6];
      cof[5] = m[2]*m[3] - m[0]*m[5];
      cof[6] = m[3]*m[7] - m[4]*m[6];
      cof[7] = m[1]*m[6] - m[0]*m[7];
      cof[8] = m[0]*m[4] - m[1]*m[3];
      det = m[0]*cof[0] + m[3]*cof[1] + m[6]*cof[2];
      absdet = det[127] ? -det : det;
      limit_thr = 128'(thr) << (2*FRAC_BITS);
      res = '0;
      if (det == 0 || absdet < limit_thr) begin
         res.singular = 1'b1;
         return res;
      end
      for (int k = 0; k < 9; k++) begin
         neg = cof[k][127] != det[127];
         num = (cof[k][127] ? -cof[k] : cof[k]) << (2*FRAC_BITS);
         quo = num / absdet;
         lim = neg ? (128'd1 << (ELEM_WIDTH-1)) : ((128'd1 << (ELEM_WIDTH-1)) - 1);
         if (quo > lim) quo = lim;
         v = neg ? -quo : quo;
         flat_out[(8-k)*ELEM_WIDTH +: ELEM_WIDTH] = v[ELEM_WIDTH-1:0];
      end
      res = {flat_out, 1'b0};
      return res;
   endfunction

   // Send one request; idle at random beforehand unless running steady.
   task automatic push_request(req_type d);
      while (!steady && $urandom_range(99) < 35) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (req_full);
      inverse_q.push_back(invert_matrix(d, threshold));
      request_count++;
   endtask

   // Drop the push strobe and wait for the clock with it low.
   task automatic end_burst();
      req_push <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      end_burst();
      while (inverse_q.size() != 0) @(posedge clock);
   endtask

   // Write the threshold only once the pipeline is empty.
   task automatic write_threshold(logic [THR_W-1:0] value);
      wait_drained();
      repeat (LATENCY_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      threshold = value;
   endtask

   function automatic req_type make_matrix(int kind);
      logic [9*ELEM_WIDTH-1:0] flat;
      logic signed [ELEM_WIDTH-1:0] e;
      for (int k = 0; k < 9; k++) begin
         case (kind)
            0: begin
               e = $urandom;
            end
            1: begin
               // about +/-4.0
               e = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            end
            default: begin
               // about +/-0.06, small determinants
               e = $signed($urandom_range(0, 1 << 13)) - (1 << 12);
            end
         endcase
         flat[(8-k)*ELEM_WIDTH +: ELEM_WIDTH] = e;
      end
      return req_type'(flat);
   endfunction

   function automatic req_type diag(elem_type a, elem_type b, elem_type c);
      req_type r;
      r = '0;
      r.m_0 = a;
      r.m_4 = b;
      r.m_8 = c;
      return r;
   endfunction

   // Third column = first + second plus a little noise: near-singular.
   function automatic req_type near_singular();
      req_type r;
      r = make_matrix(1);
      r.m_6 = r.m_0 + r.m_3 + elem_type'($urandom_range(0, 8)) - 4;
      r.m_7 = r.m_1 + r.m_4 + elem_type'($urandom_range(0, 8)) - 4;
      r.m_8 = r.m_2 + r.m_5 + elem_type'($urandom_range(0, 8)) - 4;
      return r;
   endfunction

   // Check each accepted result against the oldest prediction.
   always @(posedge clock) begin
      rsp_type                 want;
      logic [9*ELEM_WIDTH-1:0] got_flat;
      logic [9*ELEM_WIDTH-1:0] want_flat;
      if (!reset && rsp_pop && !rsp_empty) begin
         result_count++;
         if (inverse_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = inverse_q.pop_front();
            if (want.singular) singular_count++;
            got_flat  = rsp_data[9*ELEM_WIDTH:1];
            want_flat = want[9*ELEM_WIDTH:1];
            for (int k = 0; k < 9; k++) begin
               if (want_flat[(8-k)*ELEM_WIDTH +: ELEM_WIDTH] == 32'h7fffffff ||
                   want_flat[(8-k)*ELEM_WIDTH +: ELEM_WIDTH] == 32'h80000000)
                  saturate_count++;
               if (got_flat[(8-k)*ELEM_WIDTH +: ELEM_WIDTH] !==
                   want_flat[(8-k)*ELEM_WIDTH +: ELEM_WIDTH]) begin
                  $display("%0t: inv_%0d expected %h actual %h", $time, k,
                           want_flat[(8-k)*ELEM_WIDTH +: ELEM_WIDTH],
                           got_flat[(8-k)*ELEM_WIDTH +: ELEM_WIDTH]);
                  fail_count++;
               end
            end
            if (rsp_data.singular !== want.singular) begin
               $display("%0t: singular expected %b actual %b", $time,
                        want.singular, rsp_data.singular);
               fail_count++;
            end
         end
      end
      // stall the receiver at random
      rsp_pop <= !reset && (steady || $urandom_range(99) >= 35);
   end

   task automatic test_directed();
      req_type r;
      push_request(diag(32'sh10000, 32'sh10000, 32'sh10000));          // identity
      push_request('0);                                                 // all zero
      push_request(diag(32'sh20000, -32'sh40000, 32'sh8000));
      push_request(diag(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));   // max
      push_request(diag(32'sh80000000, 32'sh80000000, 32'sh80000000));   // min
      push_request(diag(32'sh80000000, 32'sh7fffffff, 32'sh1));
      push_request(diag(32'sh1, 32'sh1, 32'sh1));                        // tiny det
      push_request(diag(32'sh100, 32'sh100, -32'sh100));                  // small det, inverse +/-256
      push_request(req_type'({9{32'hffffffff}}));
      push_request(req_type'({9{32'h7fffffff}}));
      push_request(req_type'({9{32'h80000000}}));
      r = diag(32'sh10000, 32'sh10000, 32'sh10000);
      r.m_3 = 32'sh7fffffff;
      r.m_7 = 32'sh80000000;
      push_request(r);
      push_request(req_type'({32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0, 32'h0,
                              32'h0, 32'h0, 32'h10000}));             // row swap
      // determinant right at the threshold edge when the threshold is 1.0
      push_request(diag(32'sh10000, 32'sh10000, 32'sh10000));
      push_request(diag(32'sh10000, 32'sh10000, 32'shffff));
      push_request(near_singular());
      end_burst();
   endtask

   task automatic test_random(int count, int kind);
      for (int i = 0; i < count; i++) begin
         push_request(make_matrix(kind));
      end
      end_burst();
   endtask

   task automatic test_near_singular(int count);
      for (int i = 0; i < count; i++) begin
         push_request($urandom_range(3) == 0 ? make_matrix(2) : near_singular());
      end
      end_burst();
   endtask

   // Fill up, hold the sender until every result is back, then resume.
   task automatic test_drain_pause();
      test_random(40, 1);
      wait_drained();
      test_random(40, 1);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_threshold(31'h10000);
      test_directed();
      write_threshold(31'd0);
      test_directed();
      test_near_singular(150);
      write_threshold(31'h7fffffff);
      test_random(60, 1);
      test_random(40, 0);
      write_threshold(31'd1);
      test_random(300, 1);
      // run flat out for a stretch
      steady = 1'b1;
      test_random(200, 1);
      steady = 1'b0;
      test_random(150, 0);
      write_threshold(31'($urandom_range(1, 1 << 14)));
      test_near_singular(150);
      test_drain_pause();
      write_threshold(31'($urandom));
      test_random(50, 1);
      write_threshold(31'd1);
      test_random(100, 2);
      wait_drained();
      repeat (LATENCY_WAIT) @(posedge clock);
      $display("Covered %0d requests, %0d results (%0d singular, %0d saturated lanes)",
               request_count, result_count, singular_count, saturate_count);
      $display("across thresholds zero, one, 1.0, maximum and random, with stalls.");
      if (fail_count == 0 && inverse_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
